// ===== hdl/cordic_sincos_atan_unit_defines.svh =====
// ----------------------------------------------------------------------------
// cordic_sincos_atan_unit_defines
// assertion macros shared by the cordic unit
// ----------------------------------------------------------------------------
`ifndef CORDIC_SINCOS_ATAN_UNIT_DEFINES_SVH
`define CORDIC_SINCOS_ATAN_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define CSAU_ASSERT_HOLDS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define CSAU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/csau_pkg.sv =====
// ----------------------------------------------------------------------------
// csau_pkg
// types, constants and tables of the circular cordic unit
// ----------------------------------------------------------------------------
package csau_pkg;

   // operation codes
   localparam logic OP_ROTATE = 1'b0;
   localparam logic OP_VECTOR = 1'b1;

   // quadrant codes
   localparam logic [1:0] QUAD_I   = 2'd0;
   localparam logic [1:0] QUAD_II  = 2'd1;
   localparam logic [1:0] QUAD_III = 2'd2;
   localparam logic [1:0] QUAD_IV  = 2'd3;

   localparam int TAB_LEN = 9;

   // magnitude limit before vectoring
   localparam logic [29:0] VEC_MAG_LIMIT = 30'h36f602be;

   // circle constants, 2^17 = 1.0
   localparam logic [25:0] FULL_TURN_RAD    = 26'h00c90fd;
   localparam logic [25:0] FULL_TURN_DEG    = 26'h2d00000;
   localparam logic [25:0] HALF_TURN_RAD    = 26'h006487e;
   localparam logic [25:0] HALF_TURN_DEG    = 26'h1680000;
   localparam logic [25:0] QUARTER_TURN_RAD = 26'h003243f;
   localparam logic [25:0] QUARTER_TURN_DEG = 26'h0b40000;
   localparam logic [31:0] INV_GAIN_RAD     = 32'h000136e9;
   localparam logic [31:0] INV_GAIN_DEG     = 32'h000136e8;

   // floor(2^32 / full turn), used for the reduction quotient estimate
   localparam logic [12:0] RECIP_RAD = 13'((64'h1_0000_0000) / 64'(FULL_TURN_RAD));
   localparam logic [12:0] RECIP_DEG = 13'((64'h1_0000_0000) / 64'(FULL_TURN_DEG));

   // 2^31 mod full turn, undoes the offset-binary shift of the angle
   localparam logic [25:0] OFFSET_RAD = 26'((64'h8000_0000) % 64'(FULL_TURN_RAD));
   localparam logic [25:0] OFFSET_DEG = 26'((64'h8000_0000) % 64'(FULL_TURN_DEG));

   localparam logic [31:0] ATAN_ROM_RAD [TAB_LEN] = '{
      32'h0001921f, 32'h0000ed63, 32'h00007d6d, 32'h00003fab, 32'h00001ff5,
      32'h00000ffe, 32'h000007ff, 32'h000003ff, 32'h000001ff
   };
   localparam logic [31:0] ATAN_ROM_DEG [TAB_LEN] = '{
      32'h005a0000, 32'h0035214e, 32'h001c128e, 32'h000e4002, 32'h00072715,
      32'h0003946f, 32'h0001ca54, 32'h0000e52d, 32'h00007297
   };

   // one beat of the rotation datapath
   typedef struct packed {
      logic        op;
      logic        unit_deg;
      logic [1:0]  quad;
      logic        halved;
      logic        zero;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
   } csau_work_type;

   function automatic logic [25:0] full_turn(input logic unit_deg);
      return unit_deg ? FULL_TURN_DEG : FULL_TURN_RAD;
   endfunction

   function automatic logic [25:0] half_turn(input logic unit_deg);
      return unit_deg ? HALF_TURN_DEG : HALF_TURN_RAD;
   endfunction

   // angle step of one stage; past the table it keeps halving the last entry
   function automatic logic [31:0] atan_step(input logic unit_deg, input int stage,
                                             input int entries);
      logic [3:0]  idx;
      int          sh;
      logic [31:0] base;
      if (stage < entries) begin
         idx = 4'(stage);
         sh  = 0;
      end else begin
         idx = 4'(entries - 1);
         sh  = stage - entries + 1;
      end
      base = unit_deg ? ATAN_ROM_DEG[idx] : ATAN_ROM_RAD[idx];
      return base >> sh;
   endfunction

endpackage

// ===== hdl/csau_if.sv =====
// ----------------------------------------------------------------------------
// csau_if
// request and response channels of the cordic unit
// ----------------------------------------------------------------------------
interface csau_req_if;
   logic               valid;
   logic               ready;
   logic               op;
   logic               unit_deg;
   logic signed [31:0] operand_a;
   logic signed [31:0] operand_b;

   modport source (output valid, op, unit_deg, operand_a, operand_b, input ready);
   modport sink   (input valid, op, unit_deg, operand_a, operand_b, output ready);
endinterface

interface csau_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] result_a;
   logic signed [31:0] result_b;
   logic               zero_vector;

   modport source (output valid, result_a, result_b, zero_vector, input ready);
   modport sink   (input valid, result_a, result_b, zero_vector, output ready);
endinterface

// ===== hdl/csau_prep.sv =====
// ----------------------------------------------------------------------------
// csau_prep
// five-stage front end: angle reduction and quadrant fold, or abs and scaling
// ----------------------------------------------------------------------------
module csau_prep (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic                   op,
   input  logic                   unit_deg,
   input  logic [31:0]            operand_a,
   input  logic [31:0]            operand_b,
   output logic                   out_valid,
   input  logic                   out_ready,
   output csau_pkg::csau_work_type out_work
);
   import csau_pkg::*;

   typedef struct packed {
      logic        op;
      logic        unit_deg;
      logic [1:0]  quad;
      logic        zero;
      logic        halved;
      logic [30:0] px;
      logic [30:0] py;
   } csau_side_type;

   // stage enables, bubbles collapse
   logic adv1, adv2, adv3, adv4, adv5;
   logic vld1_ff, vld2_ff, vld3_ff, vld4_ff, vld5_ff;

   // stage 1
   csau_side_type side1_in, side1_ff;
   logic [31:0]   n1_in, n1_ff;
   logic [44:0]   prod1_in, prod1_ff;
   logic [30:0]   abs_a, abs_b;

   // stage 2
   csau_side_type side2_in, side2_ff;
   logic [31:0]   n2_ff;
   logic [12:0]   q_est;
   logic [33:0]   prod2_in, prod2_ff;
   logic [30:0]   mag_max;
   logic [1:0]    sh;

   // stage 3
   csau_side_type side3_ff;
   logic [33:0]   r_full, r_corr;
   logic [25:0]   r3_in, r3_ff;

   // stage 4
   csau_side_type side4_ff;
   logic [26:0]   diff;
   logic [25:0]   phi4_in, phi4_ff;

   // stage 5
   logic [25:0]   qt, qt2, qt3, fold;
   logic [1:0]    rquad;
   csau_work_type work5_in, work5_ff;

   assign adv5     = !vld5_ff || out_ready;
   assign adv4     = !vld4_ff || adv5;
   assign adv3     = !vld3_ff || adv4;
   assign adv2     = !vld2_ff || adv3;
   assign adv1     = !vld1_ff || adv2;
   assign in_ready = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
      end else begin
         if (adv1) vld1_ff <= in_valid;
         if (adv2) vld2_ff <= vld1_ff;
         if (adv3) vld3_ff <= vld2_ff;
         if (adv4) vld4_ff <= vld3_ff;
         if (adv5) vld5_ff <= vld4_ff;
      end
   end

   // stage 1: offset-binary angle times reciprocal, abs and quadrant of (x, y)
   always_comb begin
      n1_in    = {~operand_a[31], operand_a[30:0]};
      prod1_in = 45'(n1_in) * 45'(unit_deg ? RECIP_DEG : RECIP_RAD);
      abs_a    = (operand_a == 32'h8000_0000) ? 31'h7fff_ffff
               : (operand_a[31] ? 31'(-operand_a) : operand_a[30:0]);
      abs_b    = (operand_b == 32'h8000_0000) ? 31'h7fff_ffff
               : (operand_b[31] ? 31'(-operand_b) : operand_b[30:0]);
      side1_in.op       = op;
      side1_in.unit_deg = unit_deg;
      side1_in.zero     = (operand_a == 32'd0) && (operand_b == 32'd0);
      side1_in.halved   = 1'b0;
      side1_in.px       = abs_a;
      side1_in.py       = abs_b;
      if (operand_a[31]) begin
         side1_in.quad = operand_b[31] ? QUAD_III : QUAD_II;
      end else begin
         side1_in.quad = operand_b[31] ? QUAD_IV : QUAD_I;
      end
   end

   // stage 2: quotient estimate times full turn, halve (x, y) under the limit
   always_comb begin
      q_est    = prod1_ff[44:32];
      prod2_in = 34'(39'(q_est) * 39'(full_turn(side1_ff.unit_deg)));
      mag_max  = (side1_ff.px > side1_ff.py) ? side1_ff.px : side1_ff.py;
      if (mag_max <= 31'(VEC_MAG_LIMIT)) begin
         sh = 2'd0;
      end else if ((mag_max >> 1) <= 31'(VEC_MAG_LIMIT)) begin
         sh = 2'd1;
      end else begin
         sh = 2'd2;
      end
      side2_in        = side1_ff;
      side2_in.px     = side1_ff.px >> sh;
      side2_in.py     = side1_ff.py >> sh;
      side2_in.halved = (sh != 2'd0);
   end

   // stage 3: remainder, one correction step
   always_comb begin
      r_full = {2'b00, n2_ff} - prod2_ff;
      r_corr = (r_full >= 34'(full_turn(side2_ff.unit_deg)))
             ? r_full - 34'(full_turn(side2_ff.unit_deg)) : r_full;
      r3_in  = r_corr[25:0];
   end

   // stage 4: remove the offset, back into [0, full turn)
   always_comb begin
      diff = {1'b0, r3_ff} - {1'b0, (side3_ff.unit_deg ? OFFSET_DEG : OFFSET_RAD)};
      if (diff[26]) begin
         phi4_in = 26'(diff + {1'b0, full_turn(side3_ff.unit_deg)});
      end else begin
         phi4_in = diff[25:0];
      end
   end

   // stage 5: quadrant of the angle, fold into the first, seed the rotation
   always_comb begin
      qt  = side4_ff.unit_deg ? QUARTER_TURN_DEG : QUARTER_TURN_RAD;
      qt2 = qt << 1;
      qt3 = qt + qt2;
      if (phi4_ff < qt) begin
         rquad = QUAD_I;
         fold  = phi4_ff;
      end else if (phi4_ff < qt2) begin
         rquad = QUAD_II;
         fold  = half_turn(side4_ff.unit_deg) - phi4_ff;
      end else if (phi4_ff < qt3) begin
         rquad = QUAD_III;
         fold  = phi4_ff - half_turn(side4_ff.unit_deg);
      end else begin
         // includes the one-unit gap below a full turn in radians
         rquad = QUAD_IV;
         fold  = full_turn(side4_ff.unit_deg) - phi4_ff;
      end
      work5_in.op       = side4_ff.op;
      work5_in.unit_deg = side4_ff.unit_deg;
      work5_in.halved   = side4_ff.halved;
      work5_in.zero     = side4_ff.zero;
      if (side4_ff.op == OP_VECTOR) begin
         work5_in.quad = side4_ff.quad;
         work5_in.x    = {1'b0, side4_ff.px};
         work5_in.y    = {1'b0, side4_ff.py};
         work5_in.z    = 32'd0;
      end else begin
         work5_in.quad = rquad;
         work5_in.x    = side4_ff.unit_deg ? INV_GAIN_DEG : INV_GAIN_RAD;
         work5_in.y    = 32'd0;
         work5_in.z    = {6'd0, fold};
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         side1_ff <= side1_in;
         n1_ff    <= n1_in;
         prod1_ff <= prod1_in;
      end
      if (adv2) begin
         side2_ff <= side2_in;
         n2_ff    <= n1_ff;
         prod2_ff <= prod2_in;
      end
      if (adv3) begin
         side3_ff <= side2_ff;
         r3_ff    <= r3_in;
      end
      if (adv4) begin
         side4_ff <= side3_ff;
         phi4_ff  <= phi4_in;
      end
      if (adv5) begin
         work5_ff <= work5_in;
      end
   end

   assign out_valid = vld5_ff;
   assign out_work  = work5_ff;

endmodule

// ===== hdl/csau_iter.sv =====
// ----------------------------------------------------------------------------
// csau_iter
// one registered micro-rotation of the cordic chain
// ----------------------------------------------------------------------------
module csau_iter #(
   parameter int STAGE         = 0,
   parameter int TABLE_ENTRIES = 9
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  csau_pkg::csau_work_type in_work,
   output logic                    out_valid,
   input  logic                    out_ready,
   output csau_pkg::csau_work_type out_work
);
   import csau_pkg::*;

   logic          adv;
   logic          vld_ff;
   logic          dir;
   logic [31:0]   xs, ys, zstep;
   csau_work_type work_in, work_ff;

   assign adv      = !vld_ff || out_ready;
   assign in_ready = adv;

   always_comb begin
      xs    = 32'($signed(in_work.x) >>> STAGE);
      ys    = 32'($signed(in_work.y) >>> STAGE);
      zstep = atan_step(in_work.unit_deg, STAGE, TABLE_ENTRIES);
      // vectoring drives y to zero, rotation drives z to zero
      dir   = (in_work.op == OP_VECTOR) ? !in_work.y[31] : in_work.z[31];
      work_in = in_work;
      if (dir) begin
         work_in.x = in_work.x + ys;
         work_in.y = in_work.y - xs;
         work_in.z = in_work.z + zstep;
      end else begin
         work_in.x = in_work.x - ys;
         work_in.y = in_work.y + xs;
         work_in.z = in_work.z - zstep;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_work  = work_ff;

endmodule

// ===== hdl/csau_post.sv =====
// ----------------------------------------------------------------------------
// csau_post
// quadrant restore and output register
// ----------------------------------------------------------------------------
module csau_post (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  csau_pkg::csau_work_type in_work,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [31:0]             result_a,
   output logic [31:0]             result_b,
   output logic                    zero_vector
);
   import csau_pkg::*;

   logic        adv;
   logic        vld_ff;
   logic        neg_x, neg_y;
   logic [31:0] half;
   logic [31:0] ang;
   logic [31:0] res_a_in, res_a_ff;
   logic [31:0] res_b_in, res_b_ff;
   logic        zero_in, zero_ff;

   assign adv      = !vld_ff || out_ready;
   assign in_ready = adv;

   always_comb begin
      half = {6'd0, half_turn(in_work.unit_deg)};
      case (in_work.quad)
         QUAD_II:  ang = half - in_work.z;
         QUAD_III: ang = in_work.z - half;
         QUAD_IV:  ang = -in_work.z;
         default:  ang = in_work.z;
      endcase
      neg_x = (in_work.quad == QUAD_II) || (in_work.quad == QUAD_III);
      neg_y = (in_work.quad == QUAD_III) || (in_work.quad == QUAD_IV);
      if (in_work.op == OP_ROTATE) begin
         res_a_in = neg_y ? -in_work.y : in_work.y;
         res_b_in = neg_x ? -in_work.x : in_work.x;
         zero_in  = 1'b0;
      end else begin
         res_a_in = in_work.zero ? 32'd0 : ang;
         res_b_in = (in_work.zero || in_work.halved) ? 32'd0 : in_work.x;
         zero_in  = in_work.zero;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_a_ff <= res_a_in;
         res_b_ff <= res_b_in;
         zero_ff  <= zero_in;
      end
   end

   assign out_valid   = vld_ff;
   assign result_a    = res_a_ff;
   assign result_b    = res_b_ff;
   assign zero_vector = zero_ff;

endmodule

// ===== hdl/cordic_sincos_atan_unit.sv =====
// path from request beat to response valid: front end, micro-rotation chain, output register
// throughput: one beat per cycle while the response side accepts; every stage holds its own valid bit
// a stalled response lets the stages behind it fill their bubbles before req ready drops
// reset (synchronous, active high) clears all valid bits; data registers keep contents
// ----------------------------------------------------------------------------
// cordic_sincos_atan_unit
// pipelined circular cordic: sine and cosine of an angle, or angle and
// gain-scaled magnitude of a vector, in radians or degrees, 2^17 = 1.0
// ----------------------------------------------------------------------------
`include "cordic_sincos_atan_unit_defines.svh"

module cordic_sincos_atan_unit #(
   parameter int ITERATIONS    = 17,
   parameter int TABLE_ENTRIES = 9
) (
   input  logic       clock,
   input  logic       reset,
   csau_req_if.sink   req_chan,
   csau_rsp_if.source rsp_chan
);
   import csau_pkg::*;

   // chain position 0 is the front end output, position k+1 the output of
   // micro-rotation k; the last position feeds the output register
   logic [ITERATIONS:0] chain_vld;
   logic [ITERATIONS:0] chain_rdy;
   csau_work_type       chain_work [ITERATIONS+1];

   // front end: five stages
   //   1 angle in offset binary times reciprocal of a full turn; abs of x, y
   //   2 quotient estimate times full turn; halve x, y below the vectoring limit
   //   3 remainder with a single correction
   //   4 remove the offset to get the angle modulo a full turn
   //   5 fold into the first quadrant, seed x, y, z
   csau_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .op        (req_chan.op),
      .unit_deg  (req_chan.unit_deg),
      .operand_a (req_chan.operand_a),
      .operand_b (req_chan.operand_b),
      .out_valid (chain_vld[0]),
      .out_ready (chain_rdy[0]),
      .out_work  (chain_work[0])
   );

   // one register stage per micro-rotation, shift and angle step are fixed
   // per stage
   for (genvar k = 0; k < ITERATIONS; k++) begin : g_iter
      csau_iter #(
         .STAGE         (k),
         .TABLE_ENTRIES (TABLE_ENTRIES)
      ) u_iter (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_vld[k]),
         .in_ready  (chain_rdy[k]),
         .in_work   (chain_work[k]),
         .out_valid (chain_vld[k+1]),
         .out_ready (chain_rdy[k+1]),
         .out_work  (chain_work[k+1])
      );
   end

   // sign restore and output register; zero vector forces both results to 0
   csau_post u_post (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (chain_vld[ITERATIONS]),
      .in_ready    (chain_rdy[ITERATIONS]),
      .in_work     (chain_work[ITERATIONS]),
      .out_valid   (rsp_chan.valid),
      .out_ready   (rsp_chan.ready),
      .result_a    (rsp_chan.result_a),
      .result_b    (rsp_chan.result_b),
      .zero_vector (rsp_chan.zero_vector)
   );

   // zero vector beat carries zero results
   `CSAU_ASSERT_HOLDS(a_zero_result, rsp_chan.valid && rsp_chan.zero_vector,
      (rsp_chan.result_a == 32'sd0) && (rsp_chan.result_b == 32'sd0),
      "zero vector flag with nonzero result")

   // rotation chain only pushes back when every stage and the output are full
   `CSAU_ASSERT_HOLDS(a_no_bubble_stall, !chain_rdy[0],
      (&chain_vld[ITERATIONS:1]) && rsp_chan.valid,
      "cordic chain stalled with an empty stage")

   // a zero vector enters the rotation chain as the origin
   `CSAU_ASSERT_HOLDS(a_zero_seed,
      chain_vld[0] && (chain_work[0].op == OP_VECTOR) && chain_work[0].zero,
      (chain_work[0].x == 32'd0) && (chain_work[0].y == 32'd0),
      "zero vector seeded with nonzero coordinates")

   // front end beat held while the chain is stalled
   `CSAU_ASSERT_NEXT(a_prep_hold, chain_vld[0] && !chain_rdy[0],
      chain_vld[0] && $stable(chain_work[0]),
      "front end beat changed while stalled")

endmodule

// ===== verif/cordic_sincos_atan_unit_tb.sv =====
// ----------------------------------------------------------------------------
// cordic_sincos_atan_unit_tb
// self-checking bench for the pipelined circular cordic unit: a directed
// table of edge angles and vectors, then random beats in both modes and both
// units, each response checked against its typed answer or an in-bench fixed-point predictor
// ----------------------------------------------------------------------------
module cordic_sincos_atan_unit_tb;
   import csau_pkg::*;

   localparam int ITERATIONS    = 17;
   localparam int TABLE_ENTRIES = 9;

   // pipeline latency plus some slack for the final drain
   localparam int DRAIN_CYCLES  = ITERATIONS + 16;
   localparam int RANDOM_ITEMS  = 450;
   localparam int TIMEOUT_UNITS = 2_000_000;

   // circle constants, 2^17 = 1.0
   localparam longint TURN_RAD     = 64'h0c90fd;
   localparam longint TURN_DEG     = 64'h2d00000;
   localparam longint HALF_RAD     = 64'h06487e;
   localparam longint HALF_DEG     = 64'h1680000;
   localparam longint QTR_RAD      = 64'h03243f;
   localparam longint QTR_DEG      = 64'h0b40000;
   localparam longint GAIN_INV_RAD = 64'h136e9;
   localparam longint GAIN_INV_DEG = 64'h136e8;
   localparam longint MAG_LIMIT    = 64'h36f602be;

   typedef struct packed {
      logic        op;
      logic        unit_deg;
      logic [31:0] operand_a;
      logic [31:0] operand_b;
   } trig_req_type;

   typedef struct packed {
      logic [31:0] result_a;
      logic [31:0] result_b;
      logic        zero_vector;
   } trig_result_type;

   // one line of the directed table; typed rows carry their own answer
   typedef struct {
      trig_req_type    item;
      bit              typed;
      trig_result_type want;
   } dir_row_type;

   logic clock;
   logic reset;

   csau_req_if req_bus ();
   csau_rsp_if rsp_bus ();

   cordic_sincos_atan_unit #(
      .ITERATIONS    (ITERATIONS),
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   trig_result_type pending_results [$];
   int              faults;
   bit              calm;
   int              hold_left;
   bit              ready_next;
   dir_row_type     dir_rows [$];

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------

   // keep the low 32 bits, sign extended
   function automatic longint to_word(input longint v);
      return longint'(int'(v));
   endfunction

   // arctangent steps per stage, radians or degrees
   function automatic longint atan_entry(input bit deg, input int idx);
      case (idx)
         0:       return deg ? 64'h5a0000 : 64'h1921f;
         1:       return deg ? 64'h35214e : 64'h0ed63;
         2:       return deg ? 64'h1c128e : 64'h07d6d;
         3:       return deg ? 64'h0e4002 : 64'h03fab;
         4:       return deg ? 64'h072715 : 64'h01ff5;
         5:       return deg ? 64'h03946f : 64'h00ffe;
         6:       return deg ? 64'h01ca54 : 64'h007ff;
         7:       return deg ? 64'h00e52d : 64'h003ff;
         default: return deg ? 64'h007297 : 64'h001ff;
      endcase
   endfunction

   // the shift-add iterations; past the table the angle step keeps halving
   function automatic void circular_pass(input bit deg, input bit vectoring,
                                         inout longint x, inout longint y,
                                         inout longint z);
      longint xs;
      longint ys;
      longint zstep;
      bit     toward;
      zstep = 0;
      for (int i = 0; i < ITERATIONS; i++) begin
         xs = x >>> (i & 31);
         ys = y >>> (i & 31);
         if (i < TABLE_ENTRIES) zstep = atan_entry(deg, i);
         else zstep = zstep >>> 1;
         toward = vectoring ? (y >= 0) : (z < 0);
         if (toward) begin
            x = to_word(x + ys);
            y = to_word(y - xs);
            z = to_word(z + zstep);
         end else begin
            x = to_word(x - ys);
            y = to_word(y + xs);
            z = to_word(z - zstep);
         end
      end
   endfunction

   function automatic trig_result_type sincos_atan_of(input trig_req_type it);
      longint          a;
      longint          b;
      longint          x;
      longint          y;
      longint          z;
      longint          phi;
      longint          full;
      longint          half;
      longint          qtr;
      longint          px;
      longint          py;
      logic [1:0]      quad;
      bit              halved;
      trig_result_type r;
      a    = longint'($signed(it.operand_a));
      b    = longint'($signed(it.operand_b));
      full = it.unit_deg ? TURN_DEG : TURN_RAD;
      half = it.unit_deg ? HALF_DEG : HALF_RAD;
      qtr  = it.unit_deg ? QTR_DEG : QTR_RAD;
      r    = '0;
      if (it.op == OP_ROTATE) begin
         phi = a % full;
         if (phi < 0) phi = phi + full;
         // a reduced angle in the gap just below a full turn counts as fourth quadrant
         case (phi / qtr)
            0:       quad = QUAD_I;
            1:       quad = QUAD_II;
            2:       quad = QUAD_III;
            default: quad = QUAD_IV;
         endcase
         case (quad)
            QUAD_II:  phi = half - phi;
            QUAD_III: phi = phi - half;
            QUAD_IV:  phi = full - phi;
            default:  ;
         endcase
         x = it.unit_deg ? GAIN_INV_DEG : GAIN_INV_RAD;
         y = 0;
         z = phi;
         circular_pass(it.unit_deg, 1'b0, x, y, z);
         if (quad == QUAD_II || quad == QUAD_III) x = to_word(-x);
         if (quad == QUAD_III || quad == QUAD_IV) y = to_word(-y);
         r.result_a = 32'(y);
         r.result_b = 32'(x);
      end else begin
         if (a < 0) quad = (b >= 0) ? QUAD_II : QUAD_III;
         else quad = (b >= 0) ? QUAD_I : QUAD_IV;
         // the most negative coordinate saturates on its way to a magnitude
         px = (a < -64'sd2147483647) ? 64'sd2147483647 : ((a < 0) ? -a : a);
         py = (b < -64'sd2147483647) ? 64'sd2147483647 : ((b < 0) ? -b : b);
         halved = 1'b0;
         while (px > MAG_LIMIT || py > MAG_LIMIT) begin
            px = px >>> 1;
            py = py >>> 1;
            halved = 1'b1;
         end
         if (px == 0 && py == 0) begin
            r.zero_vector = 1'b1;
         end else begin
            x = px;
            y = py;
            z = 0;
            circular_pass(it.unit_deg, 1'b1, x, y, z);
            case (quad)
               QUAD_II:  z = half - z;
               QUAD_III: z = z - half;
               QUAD_IV:  z = -z;
               default:  ;
            endcase
            r.result_a = 32'(z);
            r.result_b = halved ? 32'd0 : 32'(x);
         end
      end
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------

   // gap or stall length: mostly none, sometimes short, rarely long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (calm) return 0;
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // operand mix: wide random, a few turns either unit, around the
   // vectoring limit, quadrant edges and the 32-bit extremes
   function automatic logic [31:0] pick_operand();
      longint k;
      case ($urandom_range(0, 9))
         0, 1, 2: return $urandom;
         3, 4:    return 32'($signed($urandom_range(0, 32'h3fffff)) - 32'sh200000);
         5:       return 32'($signed($urandom_range(0, 32'h5ffffff)) - 32'sh3000000);
         6: begin
            k = MAG_LIMIT + $signed($urandom_range(0, 8)) - 4;
            return $urandom_range(0, 1) ? 32'(k) : 32'(-k);
         end
         7: begin
            case ($urandom_range(0, 4))
               0:       return 32'h0000_0000;
               1:       return 32'h0000_0001;
               2:       return 32'hffff_ffff;
               3:       return 32'h7fff_ffff;
               default: return 32'h8000_0000;
            endcase
         end
         8: begin
            k = $signed($urandom_range(0, 16)) - 8;
            k = k * ($urandom_range(0, 1) ? QTR_DEG : QTR_RAD);
            return 32'(k + $signed($urandom_range(0, 4)) - 2);
         end
         default: return 32'($signed($urandom_range(0, 32)) - 16);
      endcase
   endfunction

   function automatic void note_fault(input string msg);
      faults++;
      if (faults <= 10) $display("%s", msg);
   endfunction

   // drive one request beat after an optional gap, hold it until taken
   task automatic send_beat(input trig_req_type it, input trig_result_type want,
                            input int gap);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.op        <= it.op;
      req_bus.unit_deg  <= it.unit_deg;
      req_bus.operand_a <= it.operand_a;
      req_bus.operand_b <= it.operand_b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      // expectations queue up in the order the beats are taken
      pending_results.push_back(want);
      @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // response side: random back-pressure, changed on the falling edge
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_left <= 0) begin
         if (calm || $urandom_range(0, 3) != 0) begin
            ready_next = 1'b1;
            hold_left  = $urandom_range(1, 24);
         end else begin
            ready_next = 1'b0;
            hold_left  = idle_len() + 1;
         end
      end
      hold_left = hold_left - 1;
      rsp_bus.ready <= ready_next;
   end

   // response checker, sampled on the rising edge
   always @(posedge clock) begin
      trig_result_type got;
      trig_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.result_a, rsp_bus.result_b, rsp_bus.zero_vector};
         if (pending_results.size() == 0) begin
            note_fault($sformatf("unexpected beat: a=%h b=%h zero=%b",
                                 got.result_a, got.result_b, got.zero_vector));
         end else begin
            want = pending_results.pop_front();
            if (got.result_a !== want.result_a || got.result_b !== want.result_b ||
                got.zero_vector !== want.zero_vector)
               note_fault($sformatf("mismatch: a=%h/%h b=%h/%h zero=%b/%b (got/exp)",
                                    got.result_a, want.result_a, got.result_b,
                                    want.result_b, got.zero_vector, want.zero_vector));
         end
      end
   end

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      trig_req_type it;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.op        = OP_ROTATE;
      req_bus.unit_deg  = 1'b0;
      req_bus.operand_a = '0;
      req_bus.operand_b = '0;
      calm              = 1'b0;
      faults            = 0;

      // quadrant edges, the gap below a full turn, extremes, zero vectors,
      // saturation of the most negative coordinate and the halving limit
      dir_rows = '{
         '{'{OP_ROTATE, 1'b0, 32'h0000_0000, 32'h0000_0000}, 1'b0, '0},
         '{'{OP_ROTATE, 1'b0, 32'h0003_243f, 32'h0000_0000}, 1'b0, '0},
         '{'{OP_ROTATE, 1'b0, 32'h0006_487e, 32'h0000_0000}, 1'b0, '0},
         '{'{OP_ROTATE, 1'b0, 32'h0009_6bbd, 32'h0000_0000}, 1'b0, '0},
         '{'{OP_ROTATE, 1'b0, 32'h000c_90fc, 32'h0000_0000}, 1'b0, '0},
         '{'{OP_ROTATE, 1'b0, 32'hffff_ffff, 32'hffff_ffff}, 1'b0, '0},
         '{'{OP_ROTATE, 1'b0, 32'h7fff_ffff, 32'h0000_0000}, 1'b0, '0},
         '{'{OP_ROTATE, 1'b0, 32'h8000_0000, 32'h0000_0000}, 1'b0, '0},
         '{'{OP_ROTATE, 1'b1, 32'h00b4_0000, 32'h0000_0000}, 1'b0, '0},
         '{'{OP_ROTATE, 1'b1, 32'h0168_0000, 32'h0000_0000}, 1'b0, '0},
         '{'{OP_ROTATE, 1'b1, 32'hff4c_0000, 32'h0000_0000}, 1'b0, '0},
         '{'{OP_ROTATE, 1'b1, 32'h7fff_ffff, 32'h8000_0000}, 1'b0, '0},
         '{'{OP_ROTATE, 1'b1, 32'h8000_0000, 32'h7fff_ffff}, 1'b0, '0},
         '{'{OP_VECTOR, 1'b0, 32'h0000_0000, 32'h0000_0000}, 1'b1, '{32'd0, 32'd0, 1'b1}},
         '{'{OP_VECTOR, 1'b1, 32'h0000_0000, 32'h0000_0000}, 1'b1, '{32'd0, 32'd0, 1'b1}},
         '{'{OP_VECTOR, 1'b0, 32'h0002_0000, 32'h0000_0000}, 1'b0, '0},
         '{'{OP_VECTOR, 1'b1, 32'h0000_0000, 32'h0002_0000}, 1'b0, '0},
         '{'{OP_VECTOR, 1'b0, 32'hfffe_0000, 32'h0000_0000}, 1'b0, '0},
         '{'{OP_VECTOR, 1'b1, 32'h0000_0000, 32'hfffe_0000}, 1'b0, '0},
         '{'{OP_VECTOR, 1'b0, 32'hffff_ffff, 32'hffff_ffff}, 1'b0, '0},
         '{'{OP_VECTOR, 1'b1, 32'h8000_0000, 32'h8000_0000}, 1'b0, '0},
         '{'{OP_VECTOR, 1'b0, 32'h7fff_ffff, 32'h8000_0001}, 1'b0, '0},
         '{'{OP_VECTOR, 1'b1, 32'h36f6_02be, 32'h36f6_02be}, 1'b0, '0},
         '{'{OP_VECTOR, 1'b0, 32'h36f6_02bf, 32'h0000_0001}, 1'b0, '0},
         '{'{OP_VECTOR, 1'b1, 32'h8000_0000, 32'h7fff_ffff}, 1'b0, '0}
      };

      // synchronous reset, released on a falling edge
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table: typed answers where obvious, predictor elsewhere
      foreach (dir_rows[r])
         send_beat(dir_rows[r].item,
                   dir_rows[r].typed ? dir_rows[r].want : sincos_atan_of(dir_rows[r].item),
                   idle_len());

      // random beats in both modes and both units
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // hold off once until the pipeline has drained completely
         if (n == 150) begin
            req_bus.valid <= 1'b0;
            while (pending_results.size() != 0) @(negedge clock);
            @(negedge clock);
         end
         // a stretch with no gaps and no back-pressure
         calm = (n >= 300 && n < 360);
         it.op        = 1'($urandom_range(0, 1));
         it.unit_deg  = 1'($urandom_range(0, 1));
         it.operand_a = pick_operand();
         it.operand_b = pick_operand();
         if ($urandom_range(0, 39) == 0) begin
            it.op        = OP_VECTOR;
            it.operand_a = '0;
            it.operand_b = '0;
         end
         send_beat(it, sincos_atan_of(it), idle_len());
      end
      calm = 1'b0;
      req_bus.valid <= 1'b0;

      // wait for the last beats, then give stray responses a chance to show
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (faults == 0 && pending_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // hard limit on the run, far beyond the slowest legal schedule
   initial begin
      #(TIMEOUT_UNITS);
      $display("status: fail");
      $finish;
   end

endmodule
